[sv/ssh_pkg.sv]
// shared types and constants for the space-saving heavy hitter table
package ssh_pkg;
   localparam int CMD_BITS = 2;
   localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RANK  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd3;
   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic [31:0]         key;
      logic [15:0]         increment;
      logic [4:0]          rank_len;
   } req_type;

   typedef struct packed {
      logic [31:0] result_key;
      logic [31:0] result_count;
      logic        found;
      logic        last;
   } rsp_type;
endpackage

[sv/space_saving_heavy_hitters.sv]
// space-saving heavy hitter table, top level
//
// commands enter on req_* when start is high and busy is low. add and
// clear give no result; a query gives one result; a ranking gives one
// result per listed entry (or one empty result), last marking the end.
// results appear on rsp_* for one cycle with rsp_valid; the receiver
// cannot stall them.
// slot state lives in one memory (key, count, arrival) read one slot a
// cycle through a registered read port. an add or query scans every
// slot; a query's result appears in the last cycle that busy is high.
// a ranking runs one scan per listed entry. clear is busy for one cycle.
// the user must write capacity_in_use with csr_we only while the block
// is idle; the block itself does not enforce this.
// reset empties the table (valid bits are flip-flops), sets
// capacity_in_use to 16 and the arrival sequence to zero.
module space_saving_heavy_hitters #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ssh_pkg::req_type req_data,
   output logic             rsp_valid,
   output ssh_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [4:0]       csr_wdata
);
   import ssh_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_BITS + 64;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_WRITE = 5'b00100,
      S_EMIT  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_ff;

   state_type state_ff, state_in;
   logic [CAPACITY-1:0] valid_ff, valid_in, taken_ff, taken_in;
   logic [31:0] seq_ff, seq_in;
   logic [4:0]  cap_ff;
   req_type     req_ff, req_in;
   logic [IW:0] addr_ff, addr_in;
   logic        rv_ff, rv_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic        hit_ff, hit_in, vic_ok_ff, vic_ok_in, fr_ok_ff, fr_ok_in;
   logic        best_ok_ff, best_ok_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in, vic_ff, vic_in, fr_ff, fr_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0] hit_cnt_ff, hit_cnt_in, vic_cnt_ff, vic_cnt_in, vic_age_ff, vic_age_in;
   logic [31:0] best_cnt_ff, best_cnt_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [CW-1:0] used_ff, used_in;
   logic [4:0]  nres_ff, nres_in;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff, out_in;
   logic        we;
   logic [IW-1:0] wa;
   logic [EW-1:0] wd;

   logic [KEY_BITS-1:0] ekey, rkey;
   logic [31:0] rcnt, rarr, age, capv;
   logic [4:0] want;
   logic [32:0] sum;

   assign ekey = KEY_BITS'(req_ff.key);
   assign rkey = rd_ff[EW-1:64];
   assign rcnt = rd_ff[63:32];
   assign rarr = rd_ff[31:0];
   assign age  = seq_ff - rarr;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[addr_ff[IW-1:0]];
   end

   always_comb begin
      if (cap_ff == 5'd0) capv = 32'd1;
      else if (32'(cap_ff) > 32'(CAPACITY)) capv = 32'(CAPACITY);
      else capv = 32'(cap_ff);
      want = (req_ff.rank_len > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : req_ff.rank_len;
   end

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; taken_in = taken_ff; seq_in = seq_ff;
      req_in = req_ff; addr_in = addr_ff; rv_in = 1'b0; rd_idx_in = rd_idx_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff; hit_cnt_in = hit_cnt_ff;
      vic_ok_in = vic_ok_ff; vic_in = vic_ff; vic_cnt_in = vic_cnt_ff; vic_age_in = vic_age_ff;
      fr_ok_in = fr_ok_ff; fr_in = fr_ff; used_in = used_ff;
      best_ok_in = best_ok_ff; best_in = best_ff; best_cnt_in = best_cnt_ff;
      best_key_in = best_key_ff; nres_in = nres_ff;
      out_v_in = 1'b0; out_in = out_ff;
      we = 1'b0; wa = '0; wd = '0; sum = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command == CMD_CLEAR) begin
                  valid_in = '0;
                  state_in = S_DONE;
               end else begin
                  addr_in = '0; hit_in = 1'b0; vic_ok_in = 1'b0; fr_ok_in = 1'b0;
                  used_in = '0; best_ok_in = 1'b0; taken_in = '0; nres_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (addr_ff < (IW+1)'(CAPACITY)) begin
               rv_in = 1'b1; rd_idx_in = addr_ff[IW-1:0];
               addr_in = addr_ff + (IW+1)'(1);
            end
            if (rv_ff) begin
               if (valid_ff[rd_idx_ff]) begin
                  used_in = used_ff + CW'(1);
                  if (rkey == ekey && !hit_ff) begin
                     hit_in = 1'b1; hit_idx_in = rd_idx_ff; hit_cnt_in = rcnt;
                  end
                  if (!vic_ok_ff || rcnt < vic_cnt_ff ||
                      (rcnt == vic_cnt_ff && age > vic_age_ff)) begin
                     vic_ok_in = 1'b1; vic_in = rd_idx_ff;
                     vic_cnt_in = rcnt; vic_age_in = age;
                  end
                  if (!taken_ff[rd_idx_ff] && (!best_ok_ff || rcnt > best_cnt_ff)) begin
                     best_ok_in = 1'b1; best_in = rd_idx_ff;
                     best_cnt_in = rcnt; best_key_in = rkey;
                  end
               end else if (!fr_ok_ff) begin
                  fr_ok_in = 1'b1; fr_in = rd_idx_ff;
               end
            end
            if (!rv_ff && addr_ff == (IW+1)'(CAPACITY) && !rv_in) begin
               state_in = (req_ff.command == CMD_ADD) ? S_WRITE : S_EMIT;
            end
         end
         S_WRITE: begin
            we = 1'b1;
            if (hit_ff) begin
               sum = {1'b0, hit_cnt_ff} + 33'(req_ff.increment);
               wa = hit_idx_ff;
               wd = {ekey, sum[32] ? 32'hFFFF_FFFF : sum[31:0], seq_ff};
            end else if (32'(used_ff) < capv && fr_ok_ff) begin
               wa = fr_ff; valid_in[fr_ff] = 1'b1;
               wd = {ekey, 16'd0, req_ff.increment, seq_ff};
            end else begin
               sum = {1'b0, vic_cnt_ff} + 33'(req_ff.increment);
               wa = vic_ff; we = vic_ok_ff;
               wd = {ekey, sum[32] ? 32'hFFFF_FFFF : sum[31:0], seq_ff};
            end
            seq_in = seq_ff + 32'd1;
            state_in = S_DONE;
         end
         S_EMIT: begin
            out_v_in = 1'b1;
            if (req_ff.command == CMD_QUERY) begin
               out_in.result_key = 32'(ekey);
               out_in.result_count = hit_ff ? hit_cnt_ff : 32'd0;
               out_in.found = hit_ff; out_in.last = 1'b1;
               state_in = S_DONE;
            end else if (nres_ff == 5'd0 && (want == 5'd0 || !best_ok_ff)) begin
               out_in = '0; out_in.last = 1'b1;
               state_in = S_DONE;
            end else begin
               out_in.result_key = 32'(best_key_ff);
               out_in.result_count = best_cnt_ff;
               out_in.found = 1'b1;
               nres_in = nres_ff + 5'd1;
               taken_in[best_ff] = 1'b1;
               if (nres_in == want || 32'(nres_in) == 32'(used_ff)) begin
                  out_in.last = 1'b1; state_in = S_DONE;
               end else begin
                  out_in.last = 1'b0;
                  addr_in = '0; best_ok_in = 1'b0; used_in = '0; state_in = S_SCAN;
               end
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; seq_ff <= '0; cap_ff <= 5'd16;
         rv_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; seq_ff <= seq_in;
         rv_ff <= rv_in; out_v_ff <= out_v_in;
         if (csr_we) cap_ff <= csr_wdata;
      end
      taken_ff <= taken_in; req_ff <= req_in; addr_ff <= addr_in; rd_idx_ff <= rd_idx_in;
      hit_ff <= hit_in; hit_idx_ff <= hit_idx_in; hit_cnt_ff <= hit_cnt_in;
      vic_ok_ff <= vic_ok_in; vic_ff <= vic_in; vic_cnt_ff <= vic_cnt_in;
      vic_age_ff <= vic_age_in; fr_ok_ff <= fr_ok_in; fr_ff <= fr_in; used_ff <= used_in;
      best_ok_ff <= best_ok_in; best_ff <= best_in; best_cnt_ff <= best_cnt_in;
      best_key_ff <= best_key_in; nres_ff <= nres_in; out_ff <= out_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;
endmodule
